// ----- src/brb_pkg.sv -----
`default_nettype none

package brb_pkg;

    localparam int DEPTH     = 256;
    localparam int LANES     = 8;
    localparam int PTR_W     = $clog2(DEPTH);
    localparam int LANE_W    = $clog2(LANES);
    localparam int ROWS      = DEPTH / LANES;
    localparam int ROW_W     = $clog2(ROWS);
    localparam int CNT_W     = PTR_W + 1;
    localparam int LEN_W     = 4;
    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int DATA_W    = LANES * BYTE_W;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_PEEK  = 2'd2
    } op_t;

    typedef struct packed {
        logic              we;
        logic [ROW_W-1:0]  wrow;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ROW_W-1:0]  rrow;
    } lane_ctl_t;

    typedef struct packed {
        logic [LANE_W-1:0] base;
        logic [LEN_W-1:0]  count;
    } rd_info_t;

endpackage

`default_nettype wire

// ----- src/brb_lane.sv -----
`default_nettype none

module brb_lane (
    input  wire logic                       clk,
    input  wire brb_pkg::lane_ctl_t         ctl,
    output logic [brb_pkg::BYTE_W-1:0]      rdata
);
    import brb_pkg::*;

    logic [BYTE_W-1:0] mem [ROWS];

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.wrow] <= ctl.wdata;
        end
        if (ctl.re)
        begin
            rdata <= mem[ctl.rrow];
        end
    end

endmodule

`default_nettype wire

// ----- src/brb_merge.sv -----
`default_nettype none

module brb_merge (
    input  wire logic [brb_pkg::LANES-1:0][brb_pkg::BYTE_W-1:0] lane_q,
    input  wire brb_pkg::rd_info_t                               info,
    output logic [brb_pkg::DATA_W-1:0]                           read_data
);
    import brb_pkg::*;

    // byte i of the transaction sits in lane (base + i) mod LANES
    always_comb
    begin
        logic [LANE_W-1:0] src;
        read_data = '0;
        for (int i = 0; i < LANES; i++)
        begin
            src = info.base + LANE_W'(i);
            if (LEN_W'(i) < info.count)
            begin
                read_data[i*BYTE_W +: BYTE_W] = lane_q[src];
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/byte_ring_buffer_burst_fifo.sv -----
// Byte FIFO with all-or-nothing bursts of 1 to 8 bytes.
// Command channel: a transaction (operation, length, write_data) is taken at
// a rising edge with start high and busy low. busy is always low: one
// transaction per cycle is sustained.
// Result channel: exactly one result per transaction, shown for one cycle
// with done high, in the cycle after the transaction is taken. Results cannot
// be held off; the receiver must take each one as it appears.
// Storage is eight byte-wide banks of 32 rows each; byte n of the stream
// lives in bank n mod 8, so a burst touches each bank at most once and all
// banks are written or read in the same cycle. The bank read data is
// registered and a rotate stage puts the bytes back in transaction order.
// Configuration: capacity is written with cfg_write high while idle; the
// write also empties the FIFO. Capacity 0 acts as 1, above 256 as 256.
// Reset empties the FIFO and sets capacity to 256; stored bytes are not
// cleared, none are readable until written again.
`default_nettype none

module byte_ring_buffer_burst_fifo (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic [brb_pkg::CNT_W-1:0]   capacity,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [brb_pkg::OP_W-1:0]    operation,
    input  wire logic [brb_pkg::LEN_W-1:0]   length,
    input  wire logic [brb_pkg::DATA_W-1:0]  write_data,
    output logic                             done,
    output logic [brb_pkg::DATA_W-1:0]       read_data,
    output logic [brb_pkg::LEN_W-1:0]        done_length,
    output logic [brb_pkg::CNT_W-1:0]        fill_level,
    output logic [brb_pkg::CNT_W-1:0]        free_space,
    output logic                             is_empty,
    output logic                             is_full
);
    import brb_pkg::*;

    logic [CNT_W-1:0] cap_reg,  cap_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;

    logic             done_reg, done_next;
    logic [LEN_W-1:0] dlen_reg, dlen_next;
    logic [CNT_W-1:0] lvl_reg,  lvl_next;
    logic [CNT_W-1:0] free_reg, free_next;
    logic             empty_reg, empty_next;
    logic             full_reg,  full_next;
    rd_info_t         info_reg,  info_next;

    logic             accept;
    logic             len_ok;
    logic             do_write;
    logic             do_read;
    logic             do_pop;

    lane_ctl_t                      lane_ctl [LANES];
    logic [LANES-1:0][BYTE_W-1:0]   lane_q;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign len_ok = (length != '0) && (length <= LEN_W'(LANES));

    always_comb
    begin
        do_write = accept && len_ok && (operation == OP_WRITE)
                   && ((cap_reg - fill_reg) >= CNT_W'(length));
        do_read  = accept && len_ok
                   && ((operation == OP_READ) || (operation == OP_PEEK))
                   && (fill_reg >= CNT_W'(length));
        do_pop   = do_read && (operation == OP_READ);
    end

    always_comb
    begin
        cap_next  = cap_reg;
        fill_next = fill_reg;
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        if (cfg_write)
        begin
            if (capacity == '0)
            begin
                cap_next = CNT_W'(1);
            end
            else if (capacity > CNT_W'(DEPTH))
            begin
                cap_next = CNT_W'(DEPTH);
            end
            else
            begin
                cap_next = capacity;
            end
            fill_next = '0;
            wptr_next = '0;
            rptr_next = '0;
        end
        else if (do_write)
        begin
            fill_next = fill_reg + CNT_W'(length);
            wptr_next = wptr_reg + PTR_W'(length);
        end
        else if (do_pop)
        begin
            fill_next = fill_reg - CNT_W'(length);
            rptr_next = rptr_reg + PTR_W'(length);
        end
    end

    always_comb
    begin
        done_next  = accept;
        dlen_next  = (do_write || do_read) ? length : '0;
        lvl_next   = fill_next;
        free_next  = cap_reg - fill_next;
        empty_next = (fill_next == '0);
        full_next  = (fill_next == cap_reg);
        info_next.base  = rptr_reg[LANE_W-1:0];
        info_next.count = do_read ? length : '0;
    end

    // per-bank address and data steering
    always_comb
    begin
        logic [LANE_W-1:0] woff;
        logic [LANE_W-1:0] roff;
        logic [PTR_W-1:0]  waddr;
        logic [PTR_W-1:0]  raddr;
        for (int b = 0; b < LANES; b++)
        begin
            woff  = LANE_W'(b) - wptr_reg[LANE_W-1:0];
            roff  = LANE_W'(b) - rptr_reg[LANE_W-1:0];
            waddr = wptr_reg + PTR_W'(woff);
            raddr = rptr_reg + PTR_W'(roff);
            lane_ctl[b].we    = do_write && (LEN_W'(woff) < length);
            lane_ctl[b].wrow  = waddr[PTR_W-1:LANE_W];
            lane_ctl[b].wdata = write_data[{woff, 3'b000} +: BYTE_W];
            lane_ctl[b].re    = do_read;
            lane_ctl[b].rrow  = raddr[PTR_W-1:LANE_W];
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        brb_lane u_lane (
            .clk   (clk),
            .ctl   (lane_ctl[g]),
            .rdata (lane_q[g])
        );
    end

    brb_merge u_merge (
        .lane_q    (lane_q),
        .info      (info_reg),
        .read_data (read_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CNT_W'(DEPTH);
            fill_reg  <= '0;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            done_reg  <= 1'b0;
            info_reg  <= '0;
        end
        else
        begin
            cap_reg   <= cap_next;
            fill_reg  <= fill_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            done_reg  <= done_next;
            info_reg  <= info_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dlen_reg  <= dlen_next;
        lvl_reg   <= lvl_next;
        free_reg  <= free_next;
        empty_reg <= empty_next;
        full_reg  <= full_next;
    end

    assign done        = done_reg;
    assign done_length = dlen_reg;
    assign fill_level  = lvl_reg;
    assign free_space  = free_reg;
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;

endmodule

`default_nettype wire
